@@ hw/rtl/ksl_pkg.sv @@
// ----------------------------------------------------------------------------
// ksl_pkg
// Types, codes and widths shared by the keyed sequential list files.
// ----------------------------------------------------------------------------
package ksl_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  localparam int REQ_W     = 2;
  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 32;
  localparam int POS_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int ECOUNT_W  = 6;
  localparam int SLOT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOKEY  = 3'd3,
    ST_EMPTY  = 3'd4,
    ST_BADPOS = 3'd5
  } status_t;

  // One stored list entry
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // One result transaction
  typedef struct packed {
    status_t              status;
    logic [ECOUNT_W-1:0]  entry_count;
    logic [SLOT_W-1:0]    slot_index;
    logic [KEY_W-1:0]     read_key;
    logic [PAYLOAD_W-1:0] read_payload;
  } result_t;

endpackage

@@ hw/rtl/ksl_mem.sv @@
// ----------------------------------------------------------------------------
// ksl_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ksl_mem #(
  parameter int DEPTH  = ksl_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(ksl_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  ksl_pkg::entry_t     wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output ksl_pkg::entry_t     rdata
);
  import ksl_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/ksl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ksl_ctrl
// Request sequencer: key search, entry shift and read over the entry store.
// ----------------------------------------------------------------------------
module ksl_ctrl #(
  parameter int MAX_ENTRIES = ksl_pkg::MAX_ENTRIES_DEF,
  parameter int IDX_W       = $clog2(ksl_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ksl_pkg::REQ_W-1:0]       in_req_type,
  input  logic [ksl_pkg::KEY_W-1:0]       in_key,
  input  logic [ksl_pkg::PAYLOAD_W-1:0]   in_payload,
  input  logic [ksl_pkg::POS_W-1:0]       in_position,
  output logic                            mem_we,
  output logic [IDX_W-1:0]                mem_waddr,
  output ksl_pkg::entry_t                 mem_wdata,
  output logic [IDX_W-1:0]                mem_raddr,
  input  ksl_pkg::entry_t                 mem_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output ksl_pkg::result_t                res
);
  import ksl_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_PLACE  = 6'b001000,
    S_RDATA  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  req_t                 req_r, req_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [PAYLOAD_W-1:0] pay_r, pay_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     at_r, at_nxt;
  logic [CNT_W-1:0]     sa_r, sa_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic [IDX_W-1:0]     sp_r, sp_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  status_t              status_r, status_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  entry_t               rd_r, rd_nxt;

  logic [CNT_W-1:0]     at_full;
  logic                 is_full, is_empty;

  assign is_full  = (count_r == CNT_W'(MAX_ENTRIES));
  assign is_empty = (count_r == '0);
  assign at_full  = (req_r == REQ_APPEND) ? count_r : CNT_W'(pos_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    key_nxt    = key_r;
    pay_nxt    = pay_r;
    pos_nxt    = pos_r;
    at_nxt     = at_r;
    sa_nxt     = sa_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    sp_nxt     = sp_r;
    n_nxt      = n_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    rd_nxt     = rd_r;
    mem_we     = 1'b0;
    mem_waddr  = pidx_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = sa_r[IDX_W-1:0];
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = IDX_W'(in_position);
        if (in_valid) begin
          req_nxt    = req_t'(in_req_type);
          key_nxt    = in_key;
          pay_nxt    = in_payload;
          pos_nxt    = in_position;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          rd_nxt     = '0;
          sa_nxt     = '0;
          pend_nxt   = 1'b0;
          case (req_t'(in_req_type))
            REQ_APPEND, REQ_INSERT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            REQ_REMOVE: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else if (CMP_W'(in_position) >= CMP_W'(count_r)) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_DONE;
              end else begin
                slot_nxt  = IDX_W'(in_position);
                state_nxt = S_RDATA;
              end
            end
          endcase
        end
      end

      S_SEARCH: begin
        // compare the entry read last cycle, issue the next address
        if (pend_r && (mem_rdata.key == key_r)) begin
          if (req_r == REQ_REMOVE) begin
            slot_nxt  = pidx_r;
            n_nxt     = count_r - CNT_W'(pidx_r) - CNT_W'(1);
            sp_nxt    = pidx_r + IDX_W'(1);
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            status_nxt = ST_DUP;
            state_nxt  = S_DONE;
          end
        end else if (!pend_r && (sa_r == count_r)) begin
          if (req_r == REQ_REMOVE) begin
            status_nxt = ST_NOKEY;
            state_nxt  = S_DONE;
          end else if (CMP_W'(pos_r) > CMP_W'(count_r) && req_r == REQ_INSERT) begin
            status_nxt = ST_BADPOS;
            state_nxt  = S_DONE;
          end else begin
            at_nxt    = at_full[IDX_W-1:0];
            n_nxt     = count_r - at_full;
            sp_nxt    = count_r[IDX_W-1:0] - IDX_W'(1);
            state_nxt = S_SHIFT;
          end
        end else if (sa_r != count_r) begin
          sa_nxt   = sa_r + CNT_W'(1);
          pend_nxt = 1'b1;
          pidx_nxt = sa_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_SHIFT: begin
        // read one entry ahead, write it one slot over in the next cycle
        mem_raddr = sp_r;
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (n_r != '0) begin
          n_nxt    = n_r - CNT_W'(1);
          pend_nxt = 1'b1;
          if (req_r == REQ_REMOVE) begin
            pidx_nxt = sp_r - IDX_W'(1);
            sp_nxt   = sp_r + IDX_W'(1);
          end else begin
            pidx_nxt = sp_r + IDX_W'(1);
            sp_nxt   = sp_r - IDX_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (req_r == REQ_REMOVE) begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_PLACE;
            end
          end
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = at_r;
        mem_wdata = '{key: key_r, payload: pay_r};
        count_nxt = count_r + CNT_W'(1);
        slot_nxt  = at_r;
        state_nxt = S_DONE;
      end

      S_RDATA: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    pos_r    <= pos_nxt;
    at_r     <= at_nxt;
    sa_r     <= sa_nxt;
    pidx_r   <= pidx_nxt;
    sp_r     <= sp_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    rd_r     <= rd_nxt;
  end

  assign res.status       = status_r;
  assign res.entry_count  = ECOUNT_W'(count_r);
  assign res.slot_index   = SLOT_W'(slot_r);
  assign res.read_key     = rd_r.key;
  assign res.read_payload = rd_r.payload;

endmodule

@@ hw/rtl/keyed_sequential_list_core.sv @@
// ----------------------------------------------------------------------------
// keyed_sequential_list_core
// Bounded ordered list of unique-keyed entries with append, insert at
// position, remove by key and read by index.
// ----------------------------------------------------------------------------
//  channel | ports                                                  | dir
//  --------+--------------------------------------------------------+-----
//  request | in_valid/in_ready, req_type, key, payload, position    | in
//  result  | out_valid/out_ready, status, entry_count, slot_index,  | out
//          | read_key, read_payload                                 |
//
//  A request transaction is taken only while the sequencer is idle. The key
//  search reads one entry per cycle and the shift moves one entry per
//  cycle, a rate set by the single store read port.
//  Reset clears the sequencer state, the entry count and the output valid
//  flag; the store needs no clearing.
//  The output register holds a result while out_ready is low; the next
//  request is still taken and stalls only when its own result is ready.
// ----------------------------------------------------------------------------
module keyed_sequential_list_core #(
  parameter int MAX_ENTRIES = ksl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ksl_pkg::REQ_W-1:0]       in_req_type,
  input  logic [ksl_pkg::KEY_W-1:0]       in_key,
  input  logic [ksl_pkg::PAYLOAD_W-1:0]   in_payload,
  input  logic [ksl_pkg::POS_W-1:0]       in_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ksl_pkg::STATUS_W-1:0]    out_status,
  output logic [ksl_pkg::ECOUNT_W-1:0]    out_entry_count,
  output logic [ksl_pkg::SLOT_W-1:0]      out_slot_index,
  output logic [ksl_pkg::KEY_W-1:0]       out_read_key,
  output logic [ksl_pkg::PAYLOAD_W-1:0]   out_read_payload
);
  import ksl_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;

  ksl_mem #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ksl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .in_payload  (in_payload),
    .in_position (in_position),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // load a new result when the output register is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_entry_count  = out_r.entry_count;
  assign out_slot_index   = out_r.slot_index;
  assign out_read_key     = out_r.read_key;
  assign out_read_payload = out_r.read_payload;

endmodule

@@ tb/keyed_sequential_list_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sequential_list_core_tb
// Self-checking bench for the keyed sequential list. Request transactions are
// applied to a behavioral copy of the list at the moment the core accepts
// them. Each result transaction is then compared field by field against the
// oldest queued prediction. Stimulus runs in this order: directed corner
// cases, a fill to capacity and a drain, random traffic with idle bursts on
// both channels, a long result-side hold-off, pauses that drain the pipe,
// and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module keyed_sequential_list_core_tb;
  import ksl_pkg::*;

  localparam int LIST_DEPTH = MAX_ENTRIES_DEF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic [PAYLOAD_W-1:0] in_payload = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [ECOUNT_W-1:0]  out_entry_count;
  logic [SLOT_W-1:0]    out_slot_index;
  logic [KEY_W-1:0]     out_read_key;
  logic [PAYLOAD_W-1:0] out_read_payload;

  // Behavioral copy of the list
  logic [KEY_W-1:0]     list_keys [LIST_DEPTH];
  logic [PAYLOAD_W-1:0] list_payloads [LIST_DEPTH];
  int                   list_count = 0;
  int                   peak_count = 0;

  result_t              pending_results [$];
  int                   error_count = 0;
  int                   checked_total = 0;
  int                   status_tally [8];

  bit                   src_idle_on = 1'b1;
  bit                   sink_idle_on = 1'b1;
  int                   sink_hold_left = 0;
  int                   sink_stall_left = 0;
  int                   longest_hold = 0;

  keyed_sequential_list_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_slot_index   (out_slot_index),
    .out_read_key     (out_read_key),
    .out_read_payload (out_read_payload)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("keyed_sequential_list_core_tb NOT OK");
    $finish;
  end

  // Apply one request to the list copy and return the result it should give
  function automatic result_t apply_request(req_t req, logic [KEY_W-1:0] key,
                                            logic [PAYLOAD_W-1:0] payload,
                                            logic [POS_W-1:0] position);
    result_t res;
    int      found;
    int      at;
    res   = '0;
    found = -1;
    for (int i = 0; i < list_count; i++) begin
      if (found < 0 && list_keys[i] == key) found = i;
    end
    case (req)
      REQ_APPEND, REQ_INSERT: begin
        at = (req == REQ_APPEND) ? list_count : int'(position);
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (found >= 0) begin
          res.status = ST_DUP;
        end else if (at > list_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = list_count; i > at; i--) begin
            list_keys[i]     = list_keys[i-1];
            list_payloads[i] = list_payloads[i-1];
          end
          list_keys[at]     = key;
          list_payloads[at] = payload;
          list_count++;
          res.slot_index = at[SLOT_W-1:0];
        end
      end
      REQ_REMOVE: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (found < 0) begin
          res.status = ST_NOKEY;
        end else begin
          // close the gap from the found index upward
          for (int i = found; i + 1 < list_count; i++) begin
            list_keys[i]     = list_keys[i+1];
            list_payloads[i] = list_payloads[i+1];
          end
          list_count--;
          res.slot_index = found[SLOT_W-1:0];
        end
      end
      default: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(position) >= list_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.slot_index   = position[SLOT_W-1:0];
          res.read_key     = list_keys[position];
          res.read_payload = list_payloads[position];
        end
      end
    endcase
    if (list_count > peak_count) peak_count = list_count;
    res.entry_count = list_count[ECOUNT_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    bit               held;
    do begin
      k    = KEY_W'($urandom_range(0, 65535));
      held = 1'b0;
      for (int i = 0; i < list_count; i++) begin
        if (list_keys[i] == k) held = 1'b1;
      end
    end while (held);
    return k;
  endfunction

  task automatic send_request(req_t req, logic [KEY_W-1:0] key,
                              logic [PAYLOAD_W-1:0] payload,
                              logic [POS_W-1:0] position);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    in_payload  <= payload;
    in_position <= position;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(req, key, payload, position));
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_request();
    int                   roll;
    int                   grow;
    req_t                 req;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [POS_W-1:0]     position;
    roll = $urandom_range(0, 99);
    grow = (list_count < 6) ? 70 : (list_count > 26) ? 30 : 50;
    if (roll < grow / 2)                    req = REQ_APPEND;
    else if (roll < grow)                   req = REQ_INSERT;
    else if (roll < grow + (100 - grow) / 2) req = REQ_REMOVE;
    else                                    req = REQ_READ;
    // mostly held keys or a small pool, so duplicates and hits are common
    roll = $urandom_range(0, 9);
    if (list_count > 0 && roll < 5) key = list_keys[$urandom_range(0, list_count - 1)];
    else if (roll < 8)              key = KEY_W'($urandom_range(0, 47));
    else                            key = KEY_W'($urandom_range(0, 65535));
    roll = $urandom_range(0, 15);
    payload = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
    position = POS_W'($urandom_range(0, 63));
    if ($urandom_range(0, 7) != 0) begin
      if (req == REQ_INSERT) position = POS_W'($urandom_range(0, list_count));
      else if (req == REQ_READ && list_count > 0)
        position = POS_W'($urandom_range(0, list_count - 1));
    end
    send_request(req, key, payload, position);
  endtask

  task automatic test_basic_ops();
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd0);
    send_request(REQ_REMOVE, 16'h0005, $urandom, POS_W'($urandom));
    send_request(REQ_APPEND, 16'h0000, 32'h0000_0000, POS_W'($urandom));
    send_request(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF, POS_W'($urandom));
    send_request(REQ_APPEND, 16'hFFFF, 32'h1234_5678, POS_W'($urandom));
    send_request(REQ_INSERT, 16'h1234, $urandom, 6'd0);
    send_request(REQ_INSERT, 16'hABCD, $urandom, 6'd3);
    send_request(REQ_INSERT, 16'h0101, $urandom, 6'd5);
    send_request(REQ_INSERT, 16'h0202, $urandom, 6'd63);
    send_request(REQ_INSERT, 16'h0000, $urandom, 6'd40);
    send_request(REQ_INSERT, 16'h5555, $urandom, 6'd2);
    for (int p = 0; p <= 5; p++) send_request(REQ_READ, KEY_W'($urandom), $urandom, POS_W'(p));
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd32);
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd63);
    send_request(REQ_REMOVE, 16'h7777, $urandom, POS_W'($urandom));
    send_request(REQ_REMOVE, 16'h5555, $urandom, POS_W'($urandom));
    send_request(REQ_REMOVE, 16'h1234, $urandom, POS_W'($urandom));
    send_request(REQ_REMOVE, 16'hABCD, $urandom, POS_W'($urandom));
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd0);
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd1);
  endtask

  task automatic test_fill_and_drain();
    // clear whatever the directed part left
    while (list_count > 0) send_request(REQ_REMOVE, list_keys[0], $urandom, POS_W'($urandom));
    while (list_count < LIST_DEPTH) begin
      if ($urandom_range(0, 1) == 0)
        send_request(REQ_APPEND, fresh_key(), $urandom, POS_W'($urandom));
      else
        send_request(REQ_INSERT, fresh_key(), $urandom, POS_W'($urandom_range(0, list_count)));
    end
    send_request(REQ_APPEND, fresh_key(), $urandom, POS_W'($urandom));
    send_request(REQ_APPEND, list_keys[5], $urandom, POS_W'($urandom));
    send_request(REQ_INSERT, fresh_key(), $urandom, 6'd0);
    send_request(REQ_INSERT, fresh_key(), $urandom, 6'd40);
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd31);
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd32);
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, 6'd0);
    while (list_count > 0) begin
      if ($urandom_range(0, 5) == 0)
        send_request(REQ_REMOVE, fresh_key(), $urandom, POS_W'($urandom));
      send_request(REQ_REMOVE, list_keys[$urandom_range(0, list_count - 1)], $urandom,
                   POS_W'($urandom));
    end
    send_request(REQ_REMOVE, KEY_W'($urandom), $urandom, POS_W'($urandom));
    send_request(REQ_READ,   KEY_W'($urandom), $urandom, POS_W'($urandom));
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_request();
  endtask

  // Stall the result side long enough that the core backs up into its input
  task automatic test_output_stall();
    sink_hold_left = 400;
    longest_hold   = 400;
    repeat (12) send_random_request();
  endtask

  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat (30) send_random_request();
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back(int n);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (n) send_random_request();
  endtask

  // Result side: long hold-off, random stall bursts, otherwise ready
  initial begin : result_sink
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        out_ready <= 1'b0;
        sink_hold_left--;
      end else if (sink_stall_left > 0) begin
        out_ready <= 1'b0;
        sink_stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready       <= 1'b0;
        sink_stall_left = $urandom_range(1, 11) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] expected,
                                      logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",       32'(want.status),      32'(out_status));
        check_field("entry_count",  32'(want.entry_count), 32'(out_entry_count));
        check_field("slot_index",   32'(want.slot_index),  32'(out_slot_index));
        check_field("read_key",     32'(want.read_key),    32'(out_read_key));
        check_field("read_payload", want.read_payload,     out_read_payload);
        status_tally[want.status]++;
        checked_total++;
      end
    end
  end

  initial begin : main_sequence
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_fill_and_drain();
    test_random_traffic(480);
    test_output_stall();
    test_pause_until_drained();
    test_back_to_back(200);

    wait_for_results();
    repeat (100) @(posedge clk);

    $display("Checked %0d results: ok %0d, duplicate %0d, full %0d, missing key %0d, empty %0d, bad position %0d",
             checked_total, status_tally[ST_OK], status_tally[ST_DUP], status_tally[ST_FULL],
             status_tally[ST_NOKEY], status_tally[ST_EMPTY], status_tally[ST_BADPOS]);
    $display("List peaked at %0d of %0d entries; result side held off for %0d cycles once",
             peak_count, LIST_DEPTH, longest_hold);
    if (error_count == 0) begin
      $display("keyed_sequential_list_core_tb OK");
    end else begin
      $display("keyed_sequential_list_core_tb NOT OK");
    end
    $finish;
  end

endmodule
